// ===== rtl/core/block_to_chs_command_builder_macros.svh =====
// ----------------------------------------------------------------------------
// block_to_chs_command_builder_macros
// assertion shorthands shared by the command builder modules
// ----------------------------------------------------------------------------
`ifndef BLOCK_TO_CHS_COMMAND_BUILDER_MACROS_SVH
`define BLOCK_TO_CHS_COMMAND_BUILDER_MACROS_SVH

// same-cycle implication, clocked on clk, off during rst
`define BTCCB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk, off during rst
`define BTCCB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/btccb_pkg.sv =====
// ----------------------------------------------------------------------------
// btccb_pkg
// types, constants and codes shared by the block to chs command builder
// ----------------------------------------------------------------------------
package btccb_pkg;

  localparam int NUM_DRIVES_DEF = 2;
  localparam int IN_DATA_W      = 112;
  localparam int ABS_W          = 32;
  localparam int BITS_PER_STEP  = 8;
  localparam int DIV_STEPS      = ABS_W / BITS_PER_STEP;
  localparam int FIFO_DEPTH     = 2;

  localparam logic [5:0] SPT_RESET     = 6'd17;
  localparam logic [4:0] HEADS_RESET   = 5'd4;
  localparam logic [7:0] STEP_RESET    = 8'd5;
  localparam logic [7:0] OP_READ       = 8'h08;
  localparam logic [7:0] OP_WRITE      = 8'h0a;
  localparam logic [7:0] DEFAULT_COUNT = 8'd2;

  typedef enum logic [2:0] {
    REG_SPT0   = 3'd0,
    REG_HEADS0 = 3'd1,
    REG_SPT1   = 3'd2,
    REG_HEADS1 = 3'd3,
    REG_STEP   = 3'd4
  } reg_idx_t;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_RUN,
    DIV_DONE
  } div_state_t;

  typedef enum logic [2:0] {
    BYTE_OPCODE,
    BYTE_HEAD,
    BYTE_SECTOR,
    BYTE_CYL_LO,
    BYTE_COUNT,
    BYTE_STEP
  } byte_sel_t;

  // classified request waiting for the divider
  typedef struct packed {
    logic        rejected;
    logic        command;
    logic [2:0]  drive;
    logic [31:0] abs_sec;
    logic [5:0]  spt;
    logic [4:0]  heads;
    logic [7:0]  count;
  } req_t;

  // converted address ready to be sent
  typedef struct packed {
    logic       rejected;
    logic       command;
    logic [2:0] drive;
    logic [4:0] head;
    logic [5:0] sec;
    logic [9:0] cyl;
    logic [7:0] count;
  } chs_t;

endpackage

// ===== rtl/core/block_to_chs_command_builder.sv =====
// ----------------------------------------------------------------------------
// block_to_chs_command_builder
// partition sector to cylinder/head/sector command block builder
// ----------------------------------------------------------------------------
// channels: s_* takes one read or write request, m_* gives command bytes,
// cfg_* writes drive geometry (sectors per track, heads) and the step code.
// a request that passes the drive, partition and bounds checks gives six
// bytes: opcode, drive/head, cylinder high/sector, cylinder low, count and
// step code, with m_tlast on the sixth. a refused request gives one zero
// byte with m_tlast and m_tuser set.
// a request goes through the queue, the divider and the emitter register
// before its first byte goes out; the divider takes 8 address bits a cycle.
// passing requests are paced by the byte-wide output, refused requests by
// the divider. a two-entry queue sits between the check stage and the
// divider, so new requests are taken while bytes are still going out.
// reset: synchronous, clears the queue and loads the geometry defaults
// (17 sectors, 4 heads, step code 5). when m_tready is low the current byte
// holds and the queue fills, after which s_tready drops.
// ----------------------------------------------------------------------------
module block_to_chs_command_builder import btccb_pkg::*; #(
  parameter int NUM_DRIVES = NUM_DRIVES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [2:0]           cfg_index,
  input  logic [7:0]           cfg_data,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // drive[2:0], block[34:3], partition_start[66:35], partition_sectors[98:67],
  // partition_valid[99], sector_count[107:100], zero pad[111:108]
  input  logic [IN_DATA_W-1:0] s_tdata,
  // command[0]
  input  logic [0:0]           s_tuser,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // cmd_byte[7:0]
  output logic [7:0]           m_tdata,
  output logic                 m_tlast,
  // rejected[0]
  output logic [0:0]           m_tuser
);

  logic       push_valid;
  logic       push_ready;
  req_t       push_req;
  logic       q_valid;
  logic       q_ready;
  req_t       q_req;
  logic       chs_valid;
  logic       chs_ready;
  chs_t       chs;
  logic [7:0] step_code;

  btccb_front #(
    .NUM_DRIVES (NUM_DRIVES)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_req   (push_req),
    .step_code  (step_code)
  );

  btccb_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (push_valid),
    .in_ready  (push_ready),
    .in_req    (push_req),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_req   (q_req)
  );

  btccb_divider u_divider (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (q_valid),
    .in_ready  (q_ready),
    .in_req    (q_req),
    .out_valid (chs_valid),
    .out_ready (chs_ready),
    .out_chs   (chs)
  );

  btccb_emitter u_emitter (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (chs_valid),
    .in_ready  (chs_ready),
    .in_chs    (chs),
    .step_code (step_code),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser)
  );

endmodule

// ===== rtl/core/btccb_front.sv =====
// ----------------------------------------------------------------------------
// btccb_front
// geometry registers, request check and absolute sector sum
// ----------------------------------------------------------------------------
module btccb_front import btccb_pkg::*; #(
  parameter int NUM_DRIVES = NUM_DRIVES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [2:0]           cfg_index,
  input  logic [7:0]           cfg_data,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [IN_DATA_W-1:0] s_tdata,
  input  logic [0:0]           s_tuser,
  output logic                 push_valid,
  input  logic                 push_ready,
  output req_t                 push_req,
  output logic [7:0]           step_code
);

  localparam int DRV_W = (NUM_DRIVES > 1) ? $clog2(NUM_DRIVES) : 1;

  logic [5:0] spt_reg   [NUM_DRIVES];
  logic [4:0] heads_reg [NUM_DRIVES];

  logic [2:0]       drive;
  logic [31:0]      block;
  logic [31:0]      part_start;
  logic [31:0]      part_sectors;
  logic             part_valid;
  logic [7:0]       sector_count;
  logic             drive_ok;
  logic [DRV_W-1:0] sel;
  logic [5:0]       spt_raw;
  logic [4:0]       heads_raw;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int d = 0; d < NUM_DRIVES; d++) begin
        spt_reg[d]   <= SPT_RESET;
        heads_reg[d] <= HEADS_RESET;
      end
      step_code <= STEP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      for (int d = 0; d < NUM_DRIVES; d++) begin
        if (cfg_index == 3'(int'(REG_SPT0) + 2 * d)) begin
          spt_reg[d] <= cfg_data[5:0];
        end
        if (cfg_index == 3'(int'(REG_HEADS0) + 2 * d)) begin
          heads_reg[d] <= cfg_data[4:0];
        end
      end
      if (cfg_index == REG_STEP) begin
        step_code <= cfg_data;
      end
    end
  end

  assign drive        = s_tdata[2:0];
  assign block        = s_tdata[34:3];
  assign part_start   = s_tdata[66:35];
  assign part_sectors = s_tdata[98:67];
  assign part_valid   = s_tdata[99];
  assign sector_count = s_tdata[107:100];

  assign drive_ok  = int'(drive) < NUM_DRIVES;
  assign sel       = drive_ok ? drive[DRV_W-1:0] : '0;
  assign spt_raw   = spt_reg[sel];
  assign heads_raw = heads_reg[sel];

  assign s_tready   = push_ready;
  assign push_valid = s_tvalid;

  always_comb begin
    push_req.rejected = !drive_ok || !part_valid || (block > part_sectors);
    push_req.command  = s_tuser[0];
    push_req.drive    = drive;
    push_req.abs_sec  = block + part_start;
    // a zero geometry register divides as one
    push_req.spt      = (spt_raw == '0) ? 6'd1 : spt_raw;
    push_req.heads    = (heads_raw == '0) ? 5'd1 : heads_raw;
    push_req.count    = (sector_count == '0) ? DEFAULT_COUNT : sector_count;
  end

endmodule

// ===== rtl/core/btccb_fifo.sv =====
// ----------------------------------------------------------------------------
// btccb_fifo
// short request queue between the front and the divider
// ----------------------------------------------------------------------------
module btccb_fifo import btccb_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  req_t in_req,
  output logic out_valid,
  input  logic out_ready,
  output req_t out_req
);

  localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  req_t             mem [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign in_ready  = count != CNT_W'(FIFO_DEPTH);
  assign out_valid = count != '0;
  assign out_req   = mem[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/btccb_divider.sv =====
// ----------------------------------------------------------------------------
// btccb_divider
// iterative chained division: sector by sectors per track, then track by heads
// ----------------------------------------------------------------------------
`include "block_to_chs_command_builder_macros.svh"

module btccb_divider import btccb_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  req_t in_req,
  output logic out_valid,
  input  logic out_ready,
  output chs_t out_chs
);

  localparam int STEP_W = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

  div_state_t state;
  div_state_t state_next;
  logic       load;
  logic       run;

  logic [STEP_W-1:0] step;
  logic [ABS_W-1:0]  dividend;
  logic [5:0]        rem_sec;
  logic [4:0]        rem_head;
  logic [9:0]        quo_cyl;
  logic [5:0]        spt;
  logic [4:0]        heads;
  logic              rejected;
  logic              command;
  logic [2:0]        drive;
  logic [7:0]        count;

  logic [6:0] t1;
  logic [5:0] t2;
  logic       qb;
  logic [5:0] rem_sec_next;
  logic [4:0] rem_head_next;
  logic [9:0] quo_cyl_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= DIV_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    run        = 1'b0;
    case (state)
      DIV_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = DIV_RUN;
        end
      end
      DIV_RUN: begin
        run = 1'b1;
        if (step == STEP_W'(DIV_STEPS - 1)) begin
          state_next = DIV_DONE;
        end
      end
      DIV_DONE: begin
        out_valid = 1'b1;
        in_ready  = out_ready;
        if (out_ready) begin
          state_next = in_valid ? DIV_RUN : DIV_IDLE;
        end
      end
      default: begin
        state_next = DIV_IDLE;
      end
    endcase
  end

  assign load = in_valid && in_ready;

  // quotient bits of the first division feed the second one msb first
  always_comb begin
    rem_sec_next  = rem_sec;
    rem_head_next = rem_head;
    quo_cyl_next  = quo_cyl;
    t1 = '0;
    t2 = '0;
    qb = 1'b0;
    for (int i = 0; i < BITS_PER_STEP; i++) begin
      t1 = {rem_sec_next, dividend[ABS_W-1-i]};
      qb = t1 >= {1'b0, spt};
      if (qb) begin
        t1 = t1 - {1'b0, spt};
      end
      rem_sec_next = t1[5:0];
      t2 = {rem_head_next, qb};
      if (t2 >= {1'b0, heads}) begin
        t2 = t2 - {1'b0, heads};
        quo_cyl_next = {quo_cyl_next[8:0], 1'b1};
      end else begin
        quo_cyl_next = {quo_cyl_next[8:0], 1'b0};
      end
      rem_head_next = t2[4:0];
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      step     <= '0;
      dividend <= in_req.abs_sec;
      rem_sec  <= '0;
      rem_head <= '0;
      quo_cyl  <= '0;
      spt      <= in_req.spt;
      heads    <= in_req.heads;
      rejected <= in_req.rejected;
      command  <= in_req.command;
      drive    <= in_req.drive;
      count    <= in_req.count;
    end else if (run) begin
      step     <= step + 1'b1;
      dividend <= dividend << BITS_PER_STEP;
      rem_sec  <= rem_sec_next;
      rem_head <= rem_head_next;
      quo_cyl  <= quo_cyl_next;
    end
  end

  always_comb begin
    out_chs.rejected = rejected;
    out_chs.command  = command;
    out_chs.drive    = drive;
    out_chs.head     = rem_head;
    out_chs.sec      = rem_sec;
    out_chs.cyl      = quo_cyl;
    out_chs.count    = count;
  end

  `BTCCB_ASSERT_NEXT(a_run_ends, (state == DIV_RUN) && (step == STEP_W'(DIV_STEPS - 1)), state == DIV_DONE, "divider did not finish after its last step")
  `BTCCB_ASSERT_NOW(a_rem_bound, state == DIV_DONE, (rem_sec < spt) && (rem_head < heads), "remainder not below divisor")
  `BTCCB_ASSERT_NEXT(a_result_held, out_valid && !out_ready, out_valid && $stable(quo_cyl) && $stable(rem_sec), "stalled result changed")

endmodule

// ===== rtl/core/btccb_emitter.sv =====
// ----------------------------------------------------------------------------
// btccb_emitter
// serializes one converted request into the six-byte command block
// ----------------------------------------------------------------------------
`include "block_to_chs_command_builder_macros.svh"

module btccb_emitter import btccb_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  chs_t       in_chs,
  input  logic [7:0] step_code,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,
  output logic       m_tlast,
  output logic [0:0] m_tuser
);

  logic      holding;
  byte_sel_t byte_idx;
  byte_sel_t byte_idx_next;
  chs_t      cur;
  logic      is_last;

  assign is_last  = cur.rejected || (byte_idx == BYTE_STEP);
  assign in_ready = !holding || (m_tready && is_last);
  assign m_tvalid = holding;
  assign m_tlast  = is_last;
  assign m_tuser  = cur.rejected;

  always_comb begin
    byte_idx_next = byte_idx;
    m_tdata       = '0;
    case (byte_idx)
      BYTE_OPCODE: begin
        byte_idx_next = BYTE_HEAD;
        m_tdata       = cur.command ? OP_WRITE : OP_READ;
      end
      BYTE_HEAD: begin
        byte_idx_next = BYTE_SECTOR;
        m_tdata       = {cur.drive, cur.head};
      end
      BYTE_SECTOR: begin
        byte_idx_next = BYTE_CYL_LO;
        m_tdata       = {cur.cyl[9:8], cur.sec};
      end
      BYTE_CYL_LO: begin
        byte_idx_next = BYTE_COUNT;
        m_tdata       = cur.cyl[7:0];
      end
      BYTE_COUNT: begin
        byte_idx_next = BYTE_STEP;
        m_tdata       = cur.count;
      end
      BYTE_STEP: begin
        byte_idx_next = BYTE_OPCODE;
        m_tdata       = step_code;
      end
      default: begin
        byte_idx_next = BYTE_OPCODE;
        m_tdata       = '0;
      end
    endcase
    // refused request gives a single zero byte
    if (cur.rejected) begin
      m_tdata = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      holding  <= 1'b0;
      byte_idx <= BYTE_OPCODE;
    end else if (in_valid && in_ready) begin
      holding  <= 1'b1;
      byte_idx <= BYTE_OPCODE;
    end else if (m_tvalid && m_tready) begin
      if (is_last) begin
        holding <= 1'b0;
      end else begin
        byte_idx <= byte_idx_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cur <= in_chs;
    end
  end

  `BTCCB_ASSERT_NOW(a_reject_single, m_tvalid && m_tuser[0], m_tlast, "refused request not marked last")
  `BTCCB_ASSERT_NEXT(a_block_continues, m_tvalid && m_tready && !m_tlast, m_tvalid, "command block cut short")
  `BTCCB_ASSERT_NEXT(a_load_starts, in_valid && in_ready, m_tvalid && (byte_idx == BYTE_OPCODE), "new block does not start at the opcode")

endmodule

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the block to chs command builder
// ----------------------------------------------------------------------------
// a table of directed requests runs first, at reset geometry
// random request phases follow, geometry and step code rewritten in between
// while the block is idle
// each accepted request is turned into expected command bytes, checked in order
// both stream sides idle at random, except during one steady phase
// ----------------------------------------------------------------------------
module tb;
  import btccb_pkg::*;

  localparam int unsigned RUN_LIMIT      = 10_000_000;
  localparam int          RANDOM_PHASES  = 6;
  localparam int          PHASE_REQUESTS = 48;
  localparam logic [2:0]  UNUSED_REG_IDX = 3'd6;

  typedef struct packed {
    logic        command;
    logic [2:0]  drive;
    logic [31:0] block;
    logic [31:0] part_start;
    logic [31:0] part_sectors;
    logic        part_valid;
    logic [7:0]  count;
  } request_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       rejected;
  } cmd_byte_t;

  typedef enum logic [1:0] {
    CHECK_MODEL,
    CHECK_TYPED,
    CHECK_REFUSED
  } row_check_t;

  typedef struct packed {
    request_t    req;
    row_check_t  chk;
    logic [47:0] typed_bytes;  // opcode in the low byte, step code in the high
  } row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [2:0]           cfg_index = '0;
  logic [7:0]           cfg_data = '0;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [IN_DATA_W-1:0] s_tdata = '0;
  logic [0:0]           s_tuser = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [7:0]           m_tdata;
  logic                 m_tlast;
  logic [0:0]           m_tuser;

  logic [5:0] spt_reg [2];
  logic [4:0] heads_reg [2];
  logic [7:0] step_reg;

  cmd_byte_t pending_bytes [$];
  row_t      directed_rows [$];
  int        mismatches = 0;
  int        idle_pct = 21;

  block_to_chs_command_builder uut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .m_tuser(m_tuser)
  );

  always #10 clk = ~clk;

  task automatic log_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    mismatches++;
  endtask

  // expected command bytes for one request under the current geometry
  function automatic void predict_command_block(input request_t r);
    logic [5:0]  spt;
    logic [4:0]  nheads;
    logic [31:0] abs_sec, track, head, sec, cyl;
    if (r.drive >= NUM_DRIVES_DEF || !r.part_valid || r.block > r.part_sectors) begin
      pending_bytes.push_back({8'h00, 1'b1, 1'b1});
      return;
    end
    spt    = spt_reg[r.drive[0]];
    nheads = heads_reg[r.drive[0]];
    if (spt == 0) spt = 6'd1;
    if (nheads == 0) nheads = 5'd1;
    abs_sec = r.block + r.part_start;
    track   = abs_sec / spt;
    sec     = abs_sec % spt;
    head    = track % nheads;
    cyl     = track / nheads;
    pending_bytes.push_back({(r.command ? OP_WRITE : OP_READ), 1'b0, 1'b0});
    pending_bytes.push_back({r.drive, head[4:0], 1'b0, 1'b0});
    pending_bytes.push_back({cyl[9:8], sec[5:0], 1'b0, 1'b0});
    pending_bytes.push_back({cyl[7:0], 1'b0, 1'b0});
    pending_bytes.push_back({(r.count == 0 ? DEFAULT_COUNT : r.count), 1'b0, 1'b0});
    pending_bytes.push_back({step_reg, 1'b1, 1'b0});
  endfunction

  task automatic add_row(input row_check_t chk, input logic cmd, input logic [2:0] drv,
                         input logic [31:0] blk, input logic [31:0] pstart,
                         input logic [31:0] psize, input logic pvalid,
                         input logic [7:0] cnt, input logic [47:0] typed);
    row_t row;
    row.req         = {cmd, drv, blk, pstart, psize, pvalid, cnt};
    row.chk         = chk;
    row.typed_bytes = typed;
    directed_rows.push_back(row);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [7:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_SPT0:   spt_reg[0]   = data[5:0];
      REG_HEADS0: heads_reg[0] = data[4:0];
      REG_SPT1:   spt_reg[1]   = data[5:0];
      REG_HEADS1: heads_reg[1] = data[4:0];
      REG_STEP:   step_reg     = data;
      default: ;
    endcase
  endtask

  task automatic write_geometry(input logic [7:0] spt0, input logic [7:0] h0,
                                input logic [7:0] spt1, input logic [7:0] h1,
                                input logic [7:0] step);
    write_reg(REG_SPT0, spt0);
    write_reg(REG_HEADS0, h0);
    write_reg(REG_SPT1, spt1);
    write_reg(REG_HEADS1, h1);
    write_reg(REG_STEP, step);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_request(input request_t r, input row_check_t chk,
                              input logic [47:0] typed);
    int k;
    while ($urandom_range(99, 0) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0, r.count, r.part_valid, r.part_sectors, r.part_start, r.block,
                 r.drive};
    s_tuser  <= r.command;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    case (chk)
      CHECK_TYPED: begin
        for (k = 0; k < 6; k++)
          pending_bytes.push_back({typed[8*k +: 8], (k == 5), 1'b0});
      end
      CHECK_REFUSED: pending_bytes.push_back({8'h00, 1'b1, 1'b1});
      default: predict_command_block(r);
    endcase
  endtask

  // mostly well-formed requests; the rest is noise that often gets refused
  function automatic request_t random_request();
    request_t r;
    r.command = 1'($urandom_range(1, 0));
    r.count   = 8'($urandom_range(255, 0));
    if ($urandom_range(99, 0) < 80) begin
      r.drive      = 3'($urandom_range(1, 0));
      r.part_valid = 1'b1;
      if ($urandom_range(1, 0)) begin
        r.part_sectors = $urandom_range(2000, 0);
        r.part_start   = $urandom_range(100000, 0);
      end else begin
        r.part_sectors = $urandom;
        r.part_start   = $urandom;
      end
      if ($urandom_range(7, 0) == 0)
        r.block = r.part_sectors;
      else if (r.part_sectors == '1)
        r.block = $urandom;
      else
        r.block = 32'($urandom % (r.part_sectors + 33'd1));
    end else begin
      r.drive        = 3'($urandom_range(7, 0));
      r.part_valid   = 1'($urandom_range(1, 0));
      r.block        = $urandom;
      r.part_start   = $urandom;
      r.part_sectors = $urandom;
    end
    return r;
  endfunction

  // output side: random back-pressure and in-order checking
  always @(posedge clk) begin
    cmd_byte_t exp_byte;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (pending_bytes.size() == 0) begin
          log_mismatch($sformatf("unexpected byte %02h last %0b rejected %0b",
                                 m_tdata, m_tlast, m_tuser[0]));
        end else begin
          exp_byte = pending_bytes.pop_front();
          if (m_tdata !== exp_byte.data || m_tlast !== exp_byte.last ||
              m_tuser[0] !== exp_byte.rejected)
            log_mismatch($sformatf("got byte %02h last %0b rejected %0b, want %02h %0b %0b",
                                   m_tdata, m_tlast, m_tuser[0], exp_byte.data,
                                   exp_byte.last, exp_byte.rejected));
        end
      end
      m_tready <= ($urandom_range(99, 0) < idle_pct) ? 1'b0 : 1'b1;
    end
  end

  initial begin
    #(RUN_LIMIT);
    $display("block_to_chs_command_builder verification failed");
    $finish;
  end

  initial begin
    int p, i;
    request_t r;
    spt_reg[0]   = SPT_RESET;
    spt_reg[1]   = SPT_RESET;
    heads_reg[0] = HEADS_RESET;
    heads_reg[1] = HEADS_RESET;
    step_reg     = STEP_RESET;

    // reset geometry: 17 sectors, 4 heads, step code 5
    add_row(CHECK_TYPED, 1'b0, 3'd0, 32'd0, 32'd0, 32'd100, 1'b1, 8'h01,
            {8'h05, 8'h01, 8'h00, 8'h00, 8'h00, OP_READ});
    // block equal to size, count 0 becomes 2
    add_row(CHECK_TYPED, 1'b1, 3'd1, 32'd0, 32'd0, 32'd0, 1'b1, 8'h00,
            {8'h05, 8'h02, 8'h00, 8'h00, 8'h20, OP_WRITE});
    add_row(CHECK_TYPED, 1'b0, 3'd0, 32'd16, 32'd0, 32'd100, 1'b1, 8'h80,
            {8'h05, 8'h80, 8'h00, 8'h10, 8'h00, OP_READ});
    add_row(CHECK_TYPED, 1'b0, 3'd1, 32'd0, 32'd17, 32'd100, 1'b1, 8'h03,
            {8'h05, 8'h03, 8'h00, 8'h00, 8'h21, OP_READ});
    // address sum wraps to zero
    add_row(CHECK_TYPED, 1'b1, 3'd1, 32'hffff_ffff, 32'd1, 32'hffff_ffff, 1'b1, 8'hff,
            {8'h05, 8'hff, 8'h00, 8'h00, 8'h20, OP_WRITE});
    add_row(CHECK_REFUSED, 1'b0, 3'd2, 32'd0, 32'd0, 32'd100, 1'b1, 8'h01, '0);
    add_row(CHECK_REFUSED, 1'b1, 3'd7, 32'd0, 32'd0, 32'd100, 1'b1, 8'h01, '0);
    add_row(CHECK_REFUSED, 1'b0, 3'd4, 32'd5, 32'd0, 32'd100, 1'b1, 8'h01, '0);
    add_row(CHECK_REFUSED, 1'b0, 3'd0, 32'd5, 32'd0, 32'd100, 1'b0, 8'h01, '0);
    add_row(CHECK_REFUSED, 1'b1, 3'd1, 32'd101, 32'd0, 32'd100, 1'b1, 8'h01, '0);
    add_row(CHECK_REFUSED, 1'b0, 3'd0, 32'hffff_ffff, 32'd0, 32'd0, 1'b1, 8'h01, '0);
    add_row(CHECK_REFUSED, 1'b1, 3'd3, 32'd200, 32'd0, 32'd100, 1'b0, 8'h01, '0);
    add_row(CHECK_MODEL, 1'b0, 3'd0, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 1'b1,
            8'hff, '0);
    add_row(CHECK_MODEL, 1'b1, 3'd1, 32'haaaa_aaaa, 32'h5555_5555, 32'hffff_ffff, 1'b1,
            8'haa, '0);
    add_row(CHECK_MODEL, 1'b0, 3'd0, 32'h5555_5555, 32'haaaa_aaaa, 32'hffff_fffe, 1'b1,
            8'h55, '0);
    // top cylinder that still fits in 10 bits, then the first one that does not
    add_row(CHECK_MODEL, 1'b0, 3'd1, 32'd68 * 32'd1023 + 32'd67, 32'd0, 32'hffff_ffff,
            1'b1, 8'h10, '0);
    add_row(CHECK_MODEL, 1'b1, 3'd0, 32'd0, 32'd68 * 32'd1024, 32'd10, 1'b1, 8'h20, '0);

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i])
      send_request(directed_rows[i].req, directed_rows[i].chk,
                   directed_rows[i].typed_bytes);

    for (p = 0; p < RANDOM_PHASES; p++) begin
      if (p != 0) begin
        s_tvalid <= 1'b0;
        while (pending_bytes.size() != 0) @(posedge clk);
      end
      idle_pct = (p == 3) ? 0 : 21;
      case (p)
        1: write_geometry(8'd63, 8'd16, 8'd1, 8'd1, 8'hff);
        2: write_geometry(8'd0, 8'd0, 8'd0, 8'd0, 8'h00);
        3: write_geometry(8'hff, 8'hff, 8'h3f, 8'h1f, 8'ha5);
        4: begin
          write_reg(UNUSED_REG_IDX, 8'hff);
          write_geometry(8'($urandom_range(255, 0)), 8'($urandom_range(255, 0)),
                         8'($urandom_range(255, 0)), 8'($urandom_range(255, 0)),
                         8'($urandom_range(255, 0)));
        end
        // upper data bits alone, masked down to zero geometry
        5: write_geometry(8'h40, 8'h20, 8'hc0, 8'he0, 8'h5a);
        default: ;
      endcase
      for (i = 0; i < PHASE_REQUESTS; i++) begin
        r = random_request();
        send_request(r, CHECK_MODEL, '0);
      end
    end

    s_tvalid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (24) @(posedge clk);
    if (mismatches == 0)
      $display("block_to_chs_command_builder verification clean");
    else
      $display("block_to_chs_command_builder verification failed");
    $finish;
  end

endmodule
